@@ hw/rtl/peer_time_offset_median_core_assert.svh @@
// assertion macros for the port-level checker file
`ifndef PEER_TIME_OFFSET_MEDIAN_CORE_ASSERT_SVH
`define PEER_TIME_OFFSET_MEDIAN_CORE_ASSERT_SVH

// same-cycle implication, sampled on clk, quiet in reset
`define PTOM_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ptom assertion failed");

// next-cycle implication, sampled on clk, quiet in reset
`define PTOM_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ptom assertion failed");

`endif

@@ hw/rtl/ptom_pkg.sv @@
// shared constants and types for the peer time offset median core
package ptom_pkg;

  localparam int MAX_PEERS  = 64;
  localparam int OFS_DEPTH  = MAX_PEERS + 1;
  localparam int PEER_AW    = $clog2(MAX_PEERS);
  localparam int OFS_AW     = $clog2(OFS_DEPTH);
  localparam int CNT_W      = $clog2(MAX_PEERS + 2);

  localparam int ADDR_W     = 32;
  localparam int TIME_W     = 40;
  localparam int OFS_W      = 41;
  localparam int ADJ_W      = 42;
  localparam int SAMPLES_W  = 7;
  localparam int STATUS_W   = 2;
  localparam int MEDIAN_MIN = 5;

  typedef enum logic [STATUS_W-1:0] {
    STAT_DUP     = 2'd0,
    STAT_ADDED   = 2'd1,
    STAT_UPDATED = 2'd2,
    STAT_FULL    = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SCAN,
    ST_SEED0,
    ST_SEED1,
    ST_SH_RD,
    ST_SH_CMP,
    ST_SH_LAST,
    ST_TALLY,
    ST_MED_WAIT,
    ST_DONE
  } state_t;

endpackage

@@ hw/rtl/peer_time_offset_median_core.sv @@
// running median of peer clock offsets: top level
//
// Each input transaction carries a peer address, the time that peer reports
// and the local time. The core forms offset = peer - local, rejects an address
// it has already seen (status 0), drops a new address once MAX_PEERS addresses
// are stored (status 3), and otherwise records the address and inserts the
// offset into an ascending list (status 1). The very first accepted sample is
// preceded by a seeded zero offset. Whenever the stored count is at least five
// and odd the middle entry becomes the clock offset (status 2). Each input
// transaction produces exactly one output transaction with the status, the
// count of held offsets, the current clock offset and local time plus offset.
// One item is processed at a time. Addresses live in a MAX_PEERS-entry
// synchronous ram that is scanned one entry per cycle; offsets live in a
// (MAX_PEERS+1)-entry synchronous ram and are insertion-sorted by shifting one
// entry per cycle. No clearing pass is needed after reset: only entries below
// the fill counts are ever read. The input is taken again as soon as the
// result is in the output register, even if it waits there.
module peer_time_offset_median_core (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic [ptom_pkg::ADDR_W-1:0]           in_peer_address,
  input  logic [ptom_pkg::TIME_W-1:0]           in_peer_time,
  input  logic [ptom_pkg::TIME_W-1:0]           in_local_time,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic [ptom_pkg::STATUS_W-1:0]         out_status,
  output logic [ptom_pkg::SAMPLES_W-1:0]        out_samples_held,
  output logic signed [ptom_pkg::OFS_W-1:0]     out_clock_offset,
  output logic signed [ptom_pkg::ADJ_W-1:0]     out_adjusted_time
);

  // state machine
  ptom_pkg::state_t state_r, state_nxt;

  // per-item working registers
  logic [ptom_pkg::ADDR_W-1:0]       addr_r, addr_nxt;
  logic [ptom_pkg::TIME_W-1:0]       local_r, local_nxt;
  logic signed [ptom_pkg::OFS_W-1:0] sample_r, sample_nxt;
  logic [ptom_pkg::CNT_W-1:0]        scan_idx_r, scan_idx_nxt;
  logic                              cmp_vld_r, cmp_vld_nxt;
  logic [ptom_pkg::OFS_AW-1:0]       pos_r, pos_nxt;
  ptom_pkg::status_t                 status_r, status_nxt;

  // persistent state
  logic [ptom_pkg::CNT_W-1:0]        addr_cnt_r, addr_cnt_nxt;
  logic [ptom_pkg::CNT_W-1:0]        ofs_cnt_r, ofs_cnt_nxt;
  logic signed [ptom_pkg::OFS_W-1:0] median_r, median_nxt;

  // output register
  logic                               out_valid_r;
  logic [ptom_pkg::STATUS_W-1:0]      out_status_r;
  logic [ptom_pkg::SAMPLES_W-1:0]     out_samples_r;
  logic signed [ptom_pkg::OFS_W-1:0]  out_offset_r;
  logic signed [ptom_pkg::ADJ_W-1:0]  out_adjusted_r;
  logic                               out_free;
  logic                               out_load;

  // address store ports
  logic                              a_we, a_re;
  logic [ptom_pkg::PEER_AW-1:0]      a_waddr, a_raddr;
  logic [ptom_pkg::ADDR_W-1:0]       a_rdata;

  // offset store ports
  logic                              o_we, o_re;
  logic [ptom_pkg::OFS_AW-1:0]       o_waddr, o_raddr;
  logic signed [ptom_pkg::OFS_W-1:0] o_wdata;
  logic signed [ptom_pkg::OFS_W-1:0] o_rdata;

  // decision terms
  logic hit;       // address read back matches the incoming one
  logic scan_end;  // every stored address compared without a match
  logic tbl_full;
  logic ofs_gt;    // entry below the hole is larger than the new offset
  logic med_due;
  logic sample_neg;
  logic signed [ptom_pkg::ADJ_W-1:0] adjusted;

  ptom_ram #(
    .WIDTH (ptom_pkg::ADDR_W),
    .DEPTH (ptom_pkg::MAX_PEERS)
  ) u_addr_ram (
    .clk   (clk),
    .we    (a_we),
    .waddr (a_waddr),
    .wdata (addr_r),
    .re    (a_re),
    .raddr (a_raddr),
    .rdata (a_rdata)
  );

  ptom_ram #(
    .WIDTH (ptom_pkg::OFS_W),
    .DEPTH (ptom_pkg::OFS_DEPTH)
  ) u_ofs_ram (
    .clk   (clk),
    .we    (o_we),
    .waddr (o_waddr),
    .wdata (o_wdata),
    .re    (o_re),
    .raddr (o_raddr),
    .rdata (o_rdata)
  );

  assign in_ready   = (state_r == ptom_pkg::ST_IDLE);
  assign out_free   = !out_valid_r || out_ready;
  assign out_load   = (state_r == ptom_pkg::ST_DONE) && out_free;

  assign hit        = cmp_vld_r && (a_rdata == addr_r);
  assign scan_end   = !cmp_vld_r && (scan_idx_r == addr_cnt_r);
  assign tbl_full   = (addr_cnt_r == ptom_pkg::CNT_W'(ptom_pkg::MAX_PEERS));
  assign ofs_gt     = (o_rdata > sample_r);
  assign med_due    = (ofs_cnt_r >= ptom_pkg::CNT_W'(ptom_pkg::MEDIAN_MIN)) && ofs_cnt_r[0];
  assign sample_neg = sample_r[ptom_pkg::OFS_W-1];

  // local time zero-extended plus offset sign-extended
  assign adjusted = $signed({2'b00, local_r})
                  + $signed({{(ptom_pkg::ADJ_W - ptom_pkg::OFS_W){median_r[ptom_pkg::OFS_W-1]}},
                             median_r});

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ptom_pkg::ST_IDLE: begin
        if (in_valid) state_nxt = ptom_pkg::ST_SCAN;
      end
      ptom_pkg::ST_SCAN: begin
        if (hit) begin
          state_nxt = ptom_pkg::ST_DONE;
        end else if (scan_end) begin
          if (tbl_full)                       state_nxt = ptom_pkg::ST_DONE;
          else if (ofs_cnt_r == '0)           state_nxt = ptom_pkg::ST_SEED0;
          else                                state_nxt = ptom_pkg::ST_SH_RD;
        end
      end
      ptom_pkg::ST_SEED0:   state_nxt = ptom_pkg::ST_SEED1;
      ptom_pkg::ST_SEED1:   state_nxt = ptom_pkg::ST_TALLY;
      ptom_pkg::ST_SH_RD:   state_nxt = ptom_pkg::ST_SH_CMP;
      ptom_pkg::ST_SH_CMP: begin
        if (!ofs_gt)                                   state_nxt = ptom_pkg::ST_TALLY;
        else if (pos_r == ptom_pkg::OFS_AW'(1))        state_nxt = ptom_pkg::ST_SH_LAST;
      end
      ptom_pkg::ST_SH_LAST: state_nxt = ptom_pkg::ST_TALLY;
      ptom_pkg::ST_TALLY: begin
        state_nxt = med_due ? ptom_pkg::ST_MED_WAIT : ptom_pkg::ST_DONE;
      end
      ptom_pkg::ST_MED_WAIT: state_nxt = ptom_pkg::ST_DONE;
      ptom_pkg::ST_DONE: begin
        if (out_free) state_nxt = ptom_pkg::ST_IDLE;
      end
      default: state_nxt = ptom_pkg::ST_IDLE;
    endcase
  end

  // datapath and memory control
  always_comb begin
    addr_nxt     = addr_r;
    local_nxt    = local_r;
    sample_nxt   = sample_r;
    scan_idx_nxt = scan_idx_r;
    cmp_vld_nxt  = 1'b0;
    pos_nxt      = pos_r;
    status_nxt   = status_r;
    addr_cnt_nxt = addr_cnt_r;
    ofs_cnt_nxt  = ofs_cnt_r;
    median_nxt   = median_r;
    a_we         = 1'b0;
    a_waddr      = ptom_pkg::PEER_AW'(addr_cnt_r);
    a_re         = 1'b0;
    a_raddr      = ptom_pkg::PEER_AW'(scan_idx_r);
    o_we         = 1'b0;
    o_waddr      = pos_r;
    o_wdata      = sample_r;
    o_re         = 1'b0;
    o_raddr      = pos_r - ptom_pkg::OFS_AW'(1);
    unique case (state_r)
      ptom_pkg::ST_IDLE: begin
        if (in_valid) begin
          addr_nxt     = in_peer_address;
          local_nxt    = in_local_time;
          sample_nxt   = $signed({1'b0, in_peer_time}) - $signed({1'b0, in_local_time});
          scan_idx_nxt = '0;
        end
      end
      ptom_pkg::ST_SCAN: begin
        // one read per cycle, compared when the data comes back
        a_re = (scan_idx_r < addr_cnt_r);
        if (a_re) scan_idx_nxt = scan_idx_r + ptom_pkg::CNT_W'(1);
        cmp_vld_nxt = a_re && !hit;
        if (hit) begin
          status_nxt = ptom_pkg::STAT_DUP;
        end else if (scan_end) begin
          if (tbl_full) begin
            status_nxt = ptom_pkg::STAT_FULL;
          end else begin
            a_we         = 1'b1;
            addr_cnt_nxt = addr_cnt_r + ptom_pkg::CNT_W'(1);
            pos_nxt      = ptom_pkg::OFS_AW'(ofs_cnt_r);
          end
        end
      end
      ptom_pkg::ST_SEED0: begin
        // seeded zero and first sample, equal values keep zero first
        o_we    = 1'b1;
        o_waddr = '0;
        o_wdata = sample_neg ? sample_r : '0;
      end
      ptom_pkg::ST_SEED1: begin
        o_we        = 1'b1;
        o_waddr     = ptom_pkg::OFS_AW'(1);
        o_wdata     = sample_neg ? '0 : sample_r;
        ofs_cnt_nxt = ptom_pkg::CNT_W'(2);
      end
      ptom_pkg::ST_SH_RD: begin
        o_re = 1'b1;
      end
      ptom_pkg::ST_SH_CMP: begin
        o_we = 1'b1;
        if (ofs_gt) begin
          // move the larger entry up and look one lower
          o_wdata = o_rdata;
          pos_nxt = pos_r - ptom_pkg::OFS_AW'(1);
          if (pos_r != ptom_pkg::OFS_AW'(1)) begin
            o_re    = 1'b1;
            o_raddr = pos_r - ptom_pkg::OFS_AW'(2);
          end
        end else begin
          ofs_cnt_nxt = ofs_cnt_r + ptom_pkg::CNT_W'(1);
        end
      end
      ptom_pkg::ST_SH_LAST: begin
        o_we        = 1'b1;
        ofs_cnt_nxt = ofs_cnt_r + ptom_pkg::CNT_W'(1);
      end
      ptom_pkg::ST_TALLY: begin
        if (med_due) begin
          o_re    = 1'b1;
          o_raddr = ptom_pkg::OFS_AW'(ofs_cnt_r >> 1);
        end else begin
          status_nxt = ptom_pkg::STAT_ADDED;
        end
      end
      ptom_pkg::ST_MED_WAIT: begin
        median_nxt = o_rdata;
        status_nxt = ptom_pkg::STAT_UPDATED;
      end
      ptom_pkg::ST_DONE: begin
      end
      default: begin
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ptom_pkg::ST_IDLE;
      cmp_vld_r   <= 1'b0;
      addr_cnt_r  <= '0;
      ofs_cnt_r   <= '0;
      median_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      cmp_vld_r  <= cmp_vld_nxt;
      addr_cnt_r <= addr_cnt_nxt;
      ofs_cnt_r  <= ofs_cnt_nxt;
      median_r   <= median_nxt;
      if (out_load)       out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    addr_r     <= addr_nxt;
    local_r    <= local_nxt;
    sample_r   <= sample_nxt;
    scan_idx_r <= scan_idx_nxt;
    pos_r      <= pos_nxt;
    status_r   <= status_nxt;
    if (out_load) begin
      out_status_r   <= status_r;
      out_samples_r  <= ptom_pkg::SAMPLES_W'(ofs_cnt_r);
      out_offset_r   <= median_r;
      out_adjusted_r <= adjusted;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_status        = out_status_r;
  assign out_samples_held  = out_samples_r;
  assign out_clock_offset  = out_offset_r;
  assign out_adjusted_time = out_adjusted_r;

endmodule

@@ hw/rtl/ptom_ram.sv @@
// generic single-write, single-read synchronous ram with registered read data
module ptom_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ hw/rtl/ptom_checker.sv @@
// port-level checker for the peer time offset median core, with its bind
`include "peer_time_offset_median_core_assert.svh"

module ptom_checker (
  input logic                                  clk,
  input logic                                  rst_n,
  input logic                                  in_valid,
  input logic                                  in_ready,
  input logic [ptom_pkg::ADDR_W-1:0]           in_peer_address,
  input logic [ptom_pkg::TIME_W-1:0]           in_peer_time,
  input logic [ptom_pkg::TIME_W-1:0]           in_local_time,
  input logic                                  out_valid,
  input logic                                  out_ready,
  input logic [ptom_pkg::STATUS_W-1:0]         out_status,
  input logic [ptom_pkg::SAMPLES_W-1:0]        out_samples_held,
  input logic signed [ptom_pkg::OFS_W-1:0]     out_clock_offset,
  input logic signed [ptom_pkg::ADJ_W-1:0]     out_adjusted_time
);

  // a stalled result keeps its payload
  `PTOM_ASSERT_NEXT(a_out_hold, out_valid && !out_ready,
    out_valid && $stable(out_status) && $stable(out_samples_held)
    && $stable(out_clock_offset) && $stable(out_adjusted_time))

  // a median update only happens at an odd count of five or more
  `PTOM_ASSERT_NOW(a_update_count,
    out_valid && (out_status == ptom_pkg::STAT_UPDATED),
    out_samples_held[0] && (out_samples_held >= 7'd5))

  // a plain add leaves at least the seed and one sample, and no median due
  `PTOM_ASSERT_NOW(a_added_count,
    out_valid && (out_status == ptom_pkg::STAT_ADDED),
    (out_samples_held >= 7'd2) && ((out_samples_held < 7'd5) || !out_samples_held[0]))

  // the seed always comes with the first sample, so one alone never shows
  `PTOM_ASSERT_NOW(a_never_one, out_valid, out_samples_held != 7'd1)

endmodule

bind peer_time_offset_median_core ptom_checker u_ptom_checker (.*);

@@ dv/peer_time_offset_median_core_tb.sv @@
// self-checking testbench for the peer time offset median core
module peer_time_offset_median_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    ptom_pkg::status_t                      status;
    logic [ptom_pkg::SAMPLES_W-1:0]         held;
    logic signed [ptom_pkg::OFS_W-1:0]      offset;
    logic signed [ptom_pkg::ADJ_W-1:0]      adjusted;
  } offset_result_t;

  // keeps its own address table, sorted offset list and median
  class offset_median_board;
    offset_result_t                    awaited[$];
    logic [ptom_pkg::ADDR_W-1:0]       peer_table[ptom_pkg::MAX_PEERS];
    int                                peer_cnt;
    logic signed [ptom_pkg::OFS_W-1:0] offsets[ptom_pkg::OFS_DEPTH];
    int                                offset_cnt;
    logic signed [ptom_pkg::OFS_W-1:0] median = '0;
    int                                errors;
    int                                status_seen[4];
    int                                results_seen;

    // ascending insertion, new value lands after equal ones
    function void add_offset(logic signed [ptom_pkg::OFS_W-1:0] v);
      int pos;
      pos = offset_cnt;
      if (pos >= ptom_pkg::OFS_DEPTH) return;
      while (pos > 0 && offsets[pos-1] > v) begin
        offsets[pos] = offsets[pos-1];
        pos--;
      end
      offsets[pos] = v;
      offset_cnt++;
    endfunction

    function void note_input(logic [ptom_pkg::ADDR_W-1:0] addr,
                             logic [ptom_pkg::TIME_W-1:0] pt,
                             logic [ptom_pkg::TIME_W-1:0] lt);
      offset_result_t                    r;
      logic signed [ptom_pkg::OFS_W-1:0] sample;
      bit                                known;
      known = 1'b0;
      for (int i = 0; i < peer_cnt; i++)
        if (peer_table[i] == addr) known = 1'b1;
      sample = $signed({1'b0, pt}) - $signed({1'b0, lt});
      // duplicate check wins even over a full table
      if (known) begin
        r.status = ptom_pkg::STAT_DUP;
      end else if (peer_cnt >= ptom_pkg::MAX_PEERS) begin
        r.status = ptom_pkg::STAT_FULL;
      end else begin
        peer_table[peer_cnt] = addr;
        peer_cnt++;
        if (offset_cnt == 0) add_offset('0);
        add_offset(sample);
        if (offset_cnt >= ptom_pkg::MEDIAN_MIN && offset_cnt % 2 == 1) begin
          median   = offsets[offset_cnt / 2];
          r.status = ptom_pkg::STAT_UPDATED;
        end else begin
          r.status = ptom_pkg::STAT_ADDED;
        end
      end
      r.held     = ptom_pkg::SAMPLES_W'(offset_cnt);
      r.offset   = median;
      r.adjusted = $signed({2'b00, lt}) + $signed({median[ptom_pkg::OFS_W-1], median});
      status_seen[r.status]++;
      awaited = {awaited, r};
    endfunction

    function void check_result(logic [ptom_pkg::STATUS_W-1:0] st,
                               logic [ptom_pkg::SAMPLES_W-1:0] held,
                               logic signed [ptom_pkg::OFS_W-1:0] ofs,
                               logic signed [ptom_pkg::ADJ_W-1:0] adj);
      offset_result_t e;
      results_seen++;
      if (awaited.size() == 0) begin
        $display("%0t: result with no transaction pending: status %0d held %0d",
                 $time, st, held);
        errors++;
        return;
      end
      e = awaited.pop_front();
      if (st !== e.status) begin
        $display("%0t: status expected %0d actual %0d", $time, e.status, st);
        errors++;
      end
      if (held !== e.held) begin
        $display("%0t: samples_held expected %0d actual %0d", $time, e.held, held);
        errors++;
      end
      if (ofs !== e.offset) begin
        $display("%0t: clock_offset expected %0d actual %0d", $time, e.offset, ofs);
        errors++;
      end
      if (adj !== e.adjusted) begin
        $display("%0t: adjusted_time expected %0d actual %0d", $time, e.adjusted, adj);
        errors++;
      end
    endfunction

    function int pending();
      return awaited.size();
    endfunction
  endclass

  localparam logic [ptom_pkg::TIME_W-1:0] TIME_MAX = '1;
  localparam int PHASE_ITEMS = 120;

  logic                                    clk;
  logic                                    rst_n;
  logic                                    in_valid;
  logic                                    in_ready;
  logic [ptom_pkg::ADDR_W-1:0]             in_peer_address;
  logic [ptom_pkg::TIME_W-1:0]             in_peer_time;
  logic [ptom_pkg::TIME_W-1:0]             in_local_time;
  logic                                    out_valid;
  logic                                    out_ready;
  logic [ptom_pkg::STATUS_W-1:0]           out_status;
  logic [ptom_pkg::SAMPLES_W-1:0]          out_samples_held;
  logic signed [ptom_pkg::OFS_W-1:0]       out_clock_offset;
  logic signed [ptom_pkg::ADJ_W-1:0]       out_adjusted_time;

  offset_median_board            board;
  logic [ptom_pkg::ADDR_W-1:0]   sent_addrs[$];
  int                            send_idle_pct;
  int                            recv_stall_pct;
  int                            items_sent;

  peer_time_offset_median_core dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_peer_address   (in_peer_address),
    .in_peer_time      (in_peer_time),
    .in_local_time     (in_local_time),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_status        (out_status),
    .out_samples_held  (out_samples_held),
    .out_clock_offset  (out_clock_offset),
    .out_adjusted_time (out_adjusted_time)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // result side: check on handshake, then pick the next ready level
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready)
      board.check_result(out_status, out_samples_held, out_clock_offset,
                         out_adjusted_time);
    out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // one input transaction; valid stays up into the next call when no gap is drawn
  task automatic send_item(input logic [ptom_pkg::ADDR_W-1:0] addr,
                           input logic [ptom_pkg::TIME_W-1:0] pt,
                           input logic [ptom_pkg::TIME_W-1:0] lt);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_peer_address <= addr;
    in_peer_time    <= pt;
    in_local_time   <= lt;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    board.note_input(addr, pt, lt);
    sent_addrs = {sent_addrs, addr};
    items_sent++;
  endtask

  // sender holds off until every pending result has come back
  task automatic drain();
    in_valid <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
  endtask

  function automatic logic [ptom_pkg::TIME_W-1:0] rand_time();
    logic [63:0] w;
    w = {$urandom, $urandom};
    return w[ptom_pkg::TIME_W-1:0];
  endfunction

  // mix of close clocks (equal offsets likely), extremes and wide spread
  task automatic random_item();
    logic [ptom_pkg::ADDR_W-1:0] addr;
    logic [ptom_pkg::TIME_W-1:0] pt;
    logic [ptom_pkg::TIME_W-1:0] lt;
    longint                      shifted;
    int                          mode;
    int                          delta;
    if (sent_addrs.size() == 0 || $urandom_range(99) < 25)
      addr = $urandom;
    else
      addr = sent_addrs[$urandom_range(sent_addrs.size() - 1)];
    mode = $urandom_range(9);
    if (mode < 4) begin
      lt      = rand_time();
      delta   = int'($urandom_range(16)) - 8;
      shifted = longint'(lt) + delta;
      if (shifted < 0 || shifted > longint'(TIME_MAX)) shifted = longint'(lt);
      pt = shifted[ptom_pkg::TIME_W-1:0];
    end else if (mode < 6) begin
      pt = $urandom_range(1) ? TIME_MAX : '0;
      lt = $urandom_range(1) ? TIME_MAX : '0;
    end else begin
      pt = rand_time();
      lt = rand_time();
    end
    send_item(addr, pt, lt);
  endtask

  initial begin
    int idle_plan[4];
    int stall_plan[4];
    idle_plan  = '{0, 64, 0, 24};
    stall_plan = '{0, 0, 64, 24};
    board = new();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    items_sent     = 0;
    rst_n           <= 1'b0;
    in_valid        <= 1'b0;
    in_peer_address <= '0;
    in_peer_time    <= '0;
    in_local_time   <= '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // directed: seeded zero, extreme offsets, duplicates, equal offsets, median steps
    send_item(32'h0000_0000, TIME_MAX, '0);
    send_item(32'hFFFF_FFFF, '0, TIME_MAX);
    send_item(32'h0000_0000, '0, '0);
    send_item(32'h0000_0001, 40'd5, 40'd5);
    send_item(32'h0000_0002, 40'd100, 40'd40);
    send_item(32'h0000_0003, 40'd1000, 40'd940);
    send_item(32'h0000_0004, TIME_MAX, TIME_MAX);
    send_item(32'hFFFF_FFFF, TIME_MAX, TIME_MAX);
    for (int a = 5; a <= 10; a++)
      send_item(ptom_pkg::ADDR_W'(a), TIME_MAX, '0);
    // median now at the top offset, local at the top too
    send_item(32'h0000_000A, '0, TIME_MAX);
    send_item(32'hAAAA_AAAA, 40'h55_5555_5555, 40'hAA_AAAA_AAAA);
    send_item(32'h5555_5555, 40'hAA_AAAA_AAAA, 40'h55_5555_5555);

    // random phases, a full drain in front of each
    for (int ph = 0; ph < 4; ph++) begin
      drain();
      send_idle_pct  = idle_plan[ph];
      recv_stall_pct = stall_plan[ph];
      repeat (PHASE_ITEMS) random_item();
    end

    in_valid <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (board.pending() != 0) board.errors++;

    $display("sent %0d transactions, %0d results checked, %0d peers stored",
             items_sent, board.results_seen, board.peer_cnt);
    $display("status mix: %0d duplicate, %0d added, %0d median update, %0d table full",
             board.status_seen[ptom_pkg::STAT_DUP], board.status_seen[ptom_pkg::STAT_ADDED],
             board.status_seen[ptom_pkg::STAT_UPDATED],
             board.status_seen[ptom_pkg::STAT_FULL]);
    if (board.errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // watchdog
  initial begin
    #8_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+hw/rtl
hw/rtl/ptom_pkg.sv
hw/rtl/ptom_ram.sv
hw/rtl/peer_time_offset_median_core.sv
hw/rtl/ptom_checker.sv
dv/peer_time_offset_median_core_tb.sv
